// ===== rtl/tfs_pkg.sv =====
// Shared types and constants for the timer divider factor search.
package tfs_pkg;

    localparam int DATA_W = 32;
    localparam int FAC_W  = 16;

    localparam int FACTOR_LIMIT = 65535;

    localparam logic [FAC_W-1:0]  ERR_START   = 16'hFFFF;
    localparam logic [DATA_W-1:0] CLK_RESET   = 32'd240000000;
    localparam logic [DATA_W-1:0] ERR_SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] ERR_SAT_MIN = 32'h8000_0000;

    // Operands handed to the shared divider.
    typedef struct packed {
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== rtl/timer_divider_factor_search_core.sv =====
// Top level: searches period and prescaler factors for a wanted timer frequency.
// A rejected request (zero or above clock) answers in the cycle after accept.
// Otherwise a target divide and a square root, then a divide and two multiplies per
// factor row from floor(sqrt(target)) down to 2 (or a zero error), then a final divide.
// Throughput: one request at a time, busy the whole search; the receiver cannot stall.
// Reset: synchronous active low; clears sequencer and strobe, clock register to 240 MHz.
module timer_divider_factor_search_core #(
    parameter int FACTOR_LIMIT = tfs_pkg::FACTOR_LIMIT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [tfs_pkg::DATA_W-1:0]        i_cfg_wdata,
    // request
    input  logic                              start,
    output logic                              busy,
    input  logic [tfs_pkg::DATA_W-1:0]        i_wanted_freq,
    // result
    output logic                              o_valid,
    output logic                              o_ok,
    output logic [tfs_pkg::FAC_W-1:0]         o_period_factor,
    output logic [tfs_pkg::FAC_W-1:0]         o_prescale_factor,
    output logic signed [tfs_pkg::DATA_W-1:0] o_freq_error
);

    localparam int DW = tfs_pkg::DATA_W;
    localparam int FW = tfs_pkg::FAC_W;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,  // wait for a request
        S_DIVT = 10'b00_0000_0010,  // target = clock / freq
        S_SQRT = 10'b00_0000_0100,  // integer square root, two bits per step
        S_ROW  = 10'b00_0000_1000,  // loop test for current period factor a
        S_DIVQ = 10'b00_0001_0000,  // q = target / a
        S_MUL1 = 10'b00_0010_0000,  // a * c1
        S_MUL2 = 10'b00_0100_0000,  // a * c2, error of c1
        S_CMP  = 10'b00_1000_0000,  // error of c2, keep best, next a
        S_FMUL = 10'b01_0000_0000,  // product of kept factors
        S_FDIV = 10'b10_0000_0000   // clock / product, frequency error
    } t_state;

    t_state             r_state, n_state;
    logic [DW-1:0]      r_timer_clock, n_timer_clock;
    logic               r_valid, n_valid;

    logic [DW-1:0]      r_freq, n_freq;
    logic [DW-1:0]      r_target, n_target;
    logic [FW-1:0]      r_bmax, n_bmax;
    logic [DW-1:0]      r_sq_v, n_sq_v;
    logic [DW-1:0]      r_sq_root, n_sq_root;
    logic [DW-1:0]      r_sq_bit, n_sq_bit;
    logic [3:0]         r_sq_cnt, n_sq_cnt;
    logic [FW-1:0]      r_a, n_a;
    logic [FW-1:0]      r_c1, n_c1;
    logic [FW-1:0]      r_c2, n_c2;
    logic [DW-1:0]      r_p1, n_p1;
    logic [DW-1:0]      r_p2, n_p2;
    logic [DW-1:0]      r_d1, n_d1;
    logic [FW-1:0]      r_best, n_best;
    logic [FW-1:0]      r_fa, n_fa;
    logic [FW-1:0]      r_fb, n_fb;
    logic               r_ok, n_ok;
    logic [FW-1:0]      r_period, n_period;
    logic [FW-1:0]      r_prescale, n_prescale;
    logic [DW-1:0]      r_err, n_err;

    // shared divider
    logic               div_start;
    tfs_pkg::t_div_req  div_req;
    logic               div_done;
    logic [DW-1:0]      div_quo;

    // shared multiplier
    logic [FW-1:0]      mul_x, mul_y;
    logic [DW-1:0]      mul_p;

    // helpers
    logic               accept, reject;
    logic [DW:0]        sq_sum;
    logic               sq_fits;
    logic [DW-1:0]      sq_root_nx;
    logic [DW:0]        q_inc;
    logic [FW-1:0]      row_hi;
    logic [FW-1:0]      c1_cl, c2_cl;
    logic [DW-1:0]      d2;
    logic [DW:0]        err_wide;

    tfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign accept = start && !busy;
    assign reject = (i_wanted_freq == '0) || (i_wanted_freq > r_timer_clock);

    // One 16x16 multiplier, operands picked by state.
    always_comb begin
        unique case (r_state)
            S_MUL2:  begin mul_x = r_a;  mul_y = r_c2; end
            S_FMUL:  begin mul_x = r_fa; mul_y = r_fb; end
            default: begin mul_x = r_a;  mul_y = r_c1; end
        endcase
    end
    assign mul_p = DW'(mul_x) * DW'(mul_y);

    // Square root step: test root + bit against the remaining value.
    assign sq_sum     = {1'b0, r_sq_root} + {1'b0, r_sq_bit};
    assign sq_fits    = {1'b0, r_sq_v} >= sq_sum;
    assign sq_root_nx = sq_fits ? ((r_sq_root >> 1) + r_sq_bit) : (r_sq_root >> 1);

    // Best prescaler of a row sits at q or q+1, clamped to [a, bmax-1].
    assign row_hi = r_bmax - 1'b1;
    assign q_inc  = {1'b0, div_quo} + 1'b1;
    assign c1_cl  = (div_quo < DW'(r_a)) ? r_a :
                    (div_quo > DW'(row_hi)) ? row_hi : div_quo[FW-1:0];
    assign c2_cl  = (q_inc < (DW+1)'(r_a)) ? r_a :
                    (q_inc > (DW+1)'(row_hi)) ? row_hi : q_inc[FW-1:0];

    assign d2 = (r_p2 > r_target) ? (r_p2 - r_target) : (r_target - r_p2);

    assign err_wide = {1'b0, r_freq} - {1'b0, div_quo};

    always_comb begin
        n_state       = r_state;
        n_timer_clock = r_timer_clock;
        n_valid       = 1'b0;
        n_freq        = r_freq;
        n_target      = r_target;
        n_bmax        = r_bmax;
        n_sq_v        = r_sq_v;
        n_sq_root     = r_sq_root;
        n_sq_bit      = r_sq_bit;
        n_sq_cnt      = r_sq_cnt;
        n_a           = r_a;
        n_c1          = r_c1;
        n_c2          = r_c2;
        n_p1          = r_p1;
        n_p2          = r_p2;
        n_d1          = r_d1;
        n_best        = r_best;
        n_fa          = r_fa;
        n_fb          = r_fb;
        n_ok          = r_ok;
        n_period      = r_period;
        n_prescale    = r_prescale;
        n_err         = r_err;
        div_start     = 1'b0;
        div_req       = '{dividend: r_target, divisor: DW'(r_a)};

        if (i_cfg_we) begin
            n_timer_clock = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (reject) begin
                        // zero or out-of-range frequency: answer at once
                        n_valid    = 1'b1;
                        n_ok       = 1'b0;
                        n_period   = '0;
                        n_prescale = '0;
                        n_err      = '0;
                    end else begin
                        n_freq    = i_wanted_freq;
                        div_start = 1'b1;
                        div_req   = '{dividend: r_timer_clock, divisor: i_wanted_freq};
                        n_state   = S_DIVT;
                    end
                end
            end
            S_DIVT: begin
                if (div_done) begin
                    n_target  = div_quo;
                    n_bmax    = (div_quo < DW'(FACTOR_LIMIT)) ? div_quo[FW-1:0]
                                                             : FW'(FACTOR_LIMIT);
                    n_sq_v    = div_quo;
                    n_sq_root = '0;
                    n_sq_bit  = DW'(1) << (DW - 2);
                    n_sq_cnt  = '0;
                    n_best    = tfs_pkg::ERR_START;
                    n_fa      = FW'(1);
                    n_fb      = FW'(1);
                    n_state   = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sq_fits) begin
                    n_sq_v = r_sq_v - sq_sum[DW-1:0];
                end
                n_sq_root = sq_root_nx;
                n_sq_bit  = r_sq_bit >> 2;
                n_sq_cnt  = r_sq_cnt + 1'b1;
                if (r_sq_cnt == 4'd15) begin
                    n_a     = sq_root_nx[FW-1:0];
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (r_a <= FW'(1) || r_best == '0) begin
                    n_state = S_FMUL;
                end else if (r_a >= r_bmax) begin
                    // row range empty
                    n_a = r_a - 1'b1;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIVQ;
                end
            end
            S_DIVQ: begin
                if (div_done) begin
                    n_c1    = c1_cl;
                    n_c2    = c2_cl;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_p1    = mul_p;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_p2    = mul_p;
                n_d1    = (r_p1 > r_target) ? (r_p1 - r_target) : (r_target - r_p1);
                n_state = S_CMP;
            end
            S_CMP: begin
                // c1 wins ties; strict compare keeps the first pair found
                if (d2 < r_d1) begin
                    if (d2 < DW'(r_best)) begin
                        n_best = d2[FW-1:0];
                        n_fa   = r_a;
                        n_fb   = r_c2;
                    end
                end else if (r_d1 < DW'(r_best)) begin
                    n_best = r_d1[FW-1:0];
                    n_fa   = r_a;
                    n_fb   = r_c1;
                end
                n_a     = r_a - 1'b1;
                n_state = S_ROW;
            end
            S_FMUL: begin
                // product goes straight into the divider's divisor register
                div_start = 1'b1;
                div_req   = '{dividend: r_timer_clock, divisor: mul_p};
                n_state   = S_FDIV;
            end
            S_FDIV: begin
                if (div_done) begin
                    n_valid    = 1'b1;
                    n_ok       = 1'b1;
                    n_period   = r_fa;
                    n_prescale = r_fb;
                    if (err_wide[DW] != err_wide[DW-1]) begin
                        n_err = err_wide[DW] ? tfs_pkg::ERR_SAT_MIN : tfs_pkg::ERR_SAT_MAX;
                    end else begin
                        n_err = err_wide[DW-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= 1'b0;
            r_timer_clock <= tfs_pkg::CLK_RESET;
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_timer_clock <= n_timer_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        r_freq     <= n_freq;
        r_target   <= n_target;
        r_bmax     <= n_bmax;
        r_sq_v     <= n_sq_v;
        r_sq_root  <= n_sq_root;
        r_sq_bit   <= n_sq_bit;
        r_sq_cnt   <= n_sq_cnt;
        r_a        <= n_a;
        r_c1       <= n_c1;
        r_c2       <= n_c2;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_d1       <= n_d1;
        r_best     <= n_best;
        r_fa       <= n_fa;
        r_fb       <= n_fb;
        r_ok       <= n_ok;
        r_period   <= n_period;
        r_prescale <= n_prescale;
        r_err      <= n_err;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_ok              = r_ok;
    assign o_period_factor   = r_period;
    assign o_prescale_factor = r_prescale;
    assign o_freq_error      = $signed(r_err);

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // a result is only shown once the search has handed control back
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // rejected requests carry all-zero fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_period_factor == '0 && o_prescale_factor == '0
                                && o_freq_error == '0))
        else $error("rejected request with nonzero fields");

    // accepted requests never report a zero factor
    a_ok_factors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> (o_period_factor != '0 && o_prescale_factor != '0))
        else $error("zero factor on accepted request");

    // divider only finishes while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVT || r_state == S_DIVQ || r_state == S_FDIV))
        else $error("divider done outside a wait state");

    // each compare step returns to the row test
    a_cmp_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_ROW))
        else $error("compare step did not return to row test");

endmodule

// ===== rtl/tfs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module tfs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  tfs_pkg::t_div_req            i_req,
    output logic                         o_done,
    output logic [tfs_pkg::DATA_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(tfs_pkg::DATA_W);

    logic                        r_run, n_run;
    logic                        r_done, n_done;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [tfs_pkg::DATA_W-1:0]  r_rem, n_rem;
    logic [tfs_pkg::DATA_W-1:0]  r_quo, n_quo;
    logic [tfs_pkg::DATA_W-1:0]  r_den, n_den;

    logic [tfs_pkg::DATA_W:0]    rem_sh;
    logic [tfs_pkg::DATA_W:0]    rem_sub;
    logic                        fits;

    assign rem_sh  = {r_rem, r_quo[tfs_pkg::DATA_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign fits    = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_quo = i_req.dividend;
            n_den = i_req.divisor;
        end else if (r_run) begin
            n_rem = fits ? rem_sub[tfs_pkg::DATA_W-1:0] : rem_sh[tfs_pkg::DATA_W-1:0];
            n_quo = {r_quo[tfs_pkg::DATA_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(tfs_pkg::DATA_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== tb/tb_timer_divider_factor_search_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the timer divider factor search core.
module tb_timer_divider_factor_search_core;

    // Clock, reset and run limits.
    localparam int CLK_HALF      = 4;       // 8 ns period
    localparam int RESET_CYCLES  = 11;
    // Run limit for the slowest correct run: random targets reach at most 70000
    // (about 264 rows each), directed ones start at up to 1000 rows, and the
    // sender leaves gaps after every burst.
    localparam int MAX_CYCLES    = 6_000_000;
    localparam int DRAIN_CYCLES  = 64;      // quiet time after the last result
    localparam int SETTLE_CYCLES = 8;       // idle time before a clock register write
    localparam int MAX_REPORTS   = 10;
    localparam int RAND_PER_PHASE = 20;

    // Pending stimulus: either a frequency request or a clock register write.
    typedef enum logic {REQ_FREQ, REQ_CLOCK} t_req_kind;

    typedef struct {
        t_req_kind                  kind;
        logic [tfs_pkg::DATA_W-1:0] value;
    } t_freq_req;

    // Expected answer for one frequency request.
    typedef struct {
        logic                              ok;
        logic [tfs_pkg::FAC_W-1:0]         period;
        logic [tfs_pkg::FAC_W-1:0]         prescale;
        logic signed [tfs_pkg::DATA_W-1:0] freq_err;
    } t_factor_plan;

    // Block ports; every input starts at a known value.
    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_we      = 1'b0;
    logic [tfs_pkg::DATA_W-1:0]        i_cfg_wdata   = '0;
    logic                              start         = 1'b0;
    logic [tfs_pkg::DATA_W-1:0]        i_wanted_freq = '0;
    logic                              busy;
    logic                              o_valid;
    logic                              o_ok;
    logic [tfs_pkg::FAC_W-1:0]         o_period_factor;
    logic [tfs_pkg::FAC_W-1:0]         o_prescale_factor;
    logic signed [tfs_pkg::DATA_W-1:0] o_freq_error;

    t_freq_req    req_q[$];               // requests and register writes still to send
    t_factor_plan plan_q[$];              // answers owed by the block, oldest first
    logic [tfs_pkg::DATA_W-1:0] timer_clock_m = tfs_pkg::CLK_RESET;  // copy of the register

    int          mismatches = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned idle_run   = 0;

    timer_divider_factor_search_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_wanted_freq     (i_wanted_freq),
        .o_valid           (o_valid),
        .o_ok              (o_ok),
        .o_period_factor   (o_period_factor),
        .o_prescale_factor (o_prescale_factor),
        .o_freq_error      (o_freq_error)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Bitwise integer square root; targets fit in 32 bits so the root fits in 16.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) r = trial;
        end
        return r;
    endfunction

    // Best period/prescaler pair for one request at the given timer clock.
    function automatic t_factor_plan search_factors(logic [tfs_pkg::DATA_W-1:0] freq,
                                                    logic [tfs_pkg::DATA_W-1:0] clk_hz);
        t_factor_plan    p;
        longint unsigned target, bmax, best, fa, fb, row;
        longint unsigned hi, q, c1, c2, d1, d2, prod1, prod2, quot;
        longint          diff;
        p.ok       = 1'b0;
        p.period   = '0;
        p.prescale = '0;
        p.freq_err = '0;
        // zero or above-clock frequency: rejected, all fields zero
        if (freq == 0 || freq > clk_hz) return p;

        target = {32'd0, clk_hz} / {32'd0, freq};
        bmax   = (target < tfs_pkg::FACTOR_LIMIT) ? target : tfs_pkg::FACTOR_LIMIT;
        best   = tfs_pkg::ERR_START;
        fa     = 1;
        fb     = 1;

        // Rows run from the root down to 2. The error is V-shaped in b, so
        // only floor(target/a) and the next value matter, clamped to [a, bmax-1].
        // Strictly-smaller keeps the first pair on ties; zero error ends the scan.
        for (row = floor_sqrt(target); row > 1 && best != 0; row--) begin
            if (bmax == 0 || bmax - 1 < row) continue;
            hi = bmax - 1;
            q  = target / row;
            c1 = (q < row) ? row : ((q > hi) ? hi : q);
            c2 = (q + 1 < row) ? row : ((q + 1 > hi) ? hi : q + 1);
            prod1 = row * c1;
            prod2 = row * c2;
            d1 = (prod1 > target) ? prod1 - target : target - prod1;
            d2 = (prod2 > target) ? prod2 - target : target - prod2;
            if (d2 < d1) begin
                c1 = c2;
                d1 = d2;
            end
            if (d1 < best) begin
                best = d1;
                fa   = row;
                fb   = c1;
            end
        end

        // Frequency error, saturated to 32-bit signed.
        quot = {32'd0, clk_hz} / (fa * fb);
        diff = longint'({32'd0, freq}) - longint'(quot);
        if (diff > longint'($signed(tfs_pkg::ERR_SAT_MAX)))
            p.freq_err = tfs_pkg::ERR_SAT_MAX;
        else if (diff < longint'($signed(tfs_pkg::ERR_SAT_MIN)))
            p.freq_err = tfs_pkg::ERR_SAT_MIN;
        else
            p.freq_err = diff[tfs_pkg::DATA_W-1:0];

        p.ok       = 1'b1;
        p.period   = fa[tfs_pkg::FAC_W-1:0];
        p.prescale = fb[tfs_pkg::FAC_W-1:0];
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    task automatic push_freq(logic [tfs_pkg::DATA_W-1:0] v);
        t_freq_req r;
        r.kind  = REQ_FREQ;
        r.value = v;
        req_q.push_back(r);
    endtask

    task automatic push_clock(logic [tfs_pkg::DATA_W-1:0] v);
        t_freq_req r;
        r.kind  = REQ_CLOCK;
        r.value = v;
        req_q.push_back(r);
    endtask

    // Mostly well-formed requests with a chosen target; targets stay small so
    // the row scan stays short. The rest are zero and above-clock requests.
    function automatic logic [tfs_pkg::DATA_W-1:0] pick_freq(
        logic [tfs_pkg::DATA_W-1:0] clk_hz);
        int unsigned     sel;
        longint unsigned t, flo, fhi;
        sel = $urandom_range(99, 0);
        if (sel < 6 || clk_hz == 0) return '0;
        if (sel < 14) begin
            if (clk_hz == '1) return '0;
            return $urandom_range(32'hFFFF_FFFF, clk_hz + 1);
        end
        t = (sel < 24) ? $urandom_range(70000, 1) : $urandom_range(5000, 1);
        if (t > clk_hz) t = $urandom_range(clk_hz, 1);
        // every freq in [clk/(t+1)+1, clk/t] gives target t
        fhi = clk_hz / t;
        flo = clk_hz / (t + 1) + 1;
        if (flo > fhi) flo = fhi;
        return $urandom_range(fhi[tfs_pkg::DATA_W-1:0], flo[tfs_pkg::DATA_W-1:0]);
    endfunction

    task automatic random_phase(logic [tfs_pkg::DATA_W-1:0] clk_hz);
        push_clock(clk_hz);
        for (int n = 0; n < RAND_PER_PHASE; n++) push_freq(pick_freq(clk_hz));
    endtask

    function automatic int unsigned pick_gap();
        case ($urandom_range(2, 0))
            0: return 0;
            1: return $urandom_range(20, 1);
            default: return $urandom_range(4000, 1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: sends queued requests in bursts, writes the clock register
    // only once the block has gone quiet.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        logic                       take, nx_start, nx_we;
        logic [tfs_pkg::DATA_W-1:0] nx_freq, nx_wdata;
        take     = start && !busy;
        nx_start = start && !take;     // an unaccepted request stays up
        nx_freq  = i_wanted_freq;
        nx_we    = 1'b0;
        nx_wdata = i_cfg_wdata;
        if (!i_rst_n) begin
            nx_start = 1'b0;
            idle_run = 0;
        end else begin
            if (take) begin
                // request accepted this edge: predict with the register as it is now
                plan_q.push_back(search_factors(i_wanted_freq, timer_clock_m));
                void'(req_q.pop_front());
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(12, 1);
                    gap_left   = pick_gap();
                end
            end
            if (!nx_start && req_q.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (req_q[0].kind == REQ_FREQ) begin
                    nx_start = 1'b1;
                    nx_freq  = req_q[0].value;
                end else if (plan_q.size() == 0 && !busy && !o_valid) begin
                    // all answers in and block idle; hold a few cycles, then write
                    if (idle_run >= SETTLE_CYCLES) begin
                        nx_we         = 1'b1;
                        nx_wdata      = req_q[0].value;
                        timer_clock_m = req_q[0].value;
                        void'(req_q.pop_front());
                        idle_run = 0;
                    end else begin
                        idle_run++;
                    end
                end else begin
                    idle_run = 0;
                end
            end
        end
        start         <= nx_start;
        i_wanted_freq <= nx_freq;
        i_cfg_we      <= nx_we;
        i_cfg_wdata   <= nx_wdata;
    end

    // ------------------------------------------------------------------
    // Monitor: each strobed result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check
        t_factor_plan want;
        if (i_rst_n && o_valid) begin
            if (plan_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: ok=%0d period=%0d prescale=%0d err=%0d",
                             o_ok, o_period_factor, o_prescale_factor, o_freq_error);
            end else begin
                want = plan_q.pop_front();
                if (o_ok !== want.ok || o_period_factor !== want.period ||
                    o_prescale_factor !== want.prescale || o_freq_error !== want.freq_err) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: exp ok=%0d period=%0d prescale=%0d err=%0d",
                                  " | got ok=%0d period=%0d prescale=%0d err=%0d"},
                                 want.ok, want.period, want.prescale, want.freq_err,
                                 o_ok, o_period_factor, o_prescale_factor, o_freq_error);
                end
            end
        end
    end

    // Watchdog: a hung search ends the run.
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [tfs_pkg::DATA_W-1:0] rclk;

        // Reset clock value (240 MHz), before any write.
        push_freq(32'd0);             // zero frequency: rejected
        push_freq(32'd240_000_000);   // target 1: no pair, factors 1/1
        push_freq(32'd240_000_001);   // just above clock: rejected
        push_freq(32'hFFFF_FFFF);     // field maximum: rejected
        push_freq(32'd80_000_000);    // target 3: below 4, factors 1/1
        push_freq(32'd60_000_000);    // target 4: smallest real search
        push_freq(32'd240);           // target 1e6: b clamped below the factor limit
        push_freq(32'd1000);          // target 240000

        // Clock at its maximum.
        push_clock(32'hFFFF_FFFF);
        push_freq(32'hFFFF_FFFF);     // freq equal to clock
        push_freq(32'h8000_0000);     // target 1
        push_freq(32'h5555_5555);     // target 3: error saturates negative
        push_freq(32'd65536);         // target 65535: bmax at the factor limit
        push_freq(32'd65537);         // target 65535 as well, with no remainder
        push_freq(32'd1_000_000);

        // Clock at its minimum.
        push_clock(32'd1);
        push_freq(32'd1);
        push_freq(32'd2);
        push_freq(32'd0);

        // Zero clock rejects everything.
        push_clock(32'd0);
        push_freq(32'd0);
        push_freq(32'd1);
        push_freq(32'hFFFF_FFFF);

        // Random phases, each behind a fresh clock setting.
        random_phase($urandom() | 32'h8000_0000);
        random_phase($urandom_range(5000, 1));
        random_phase($urandom_range(300_000_000, 1_000_000));
        rclk = $urandom();
        random_phase((rclk == 0) ? 32'd1 : rclk);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go out and every answer to come back.
        while (req_q.size() != 0 || start || plan_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && plan_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
